// ----- sv/sbsh_pkg.sv -----
// Package with SHA-256 constants, types and rotate and message-schedule functions shared by the hasher modules.
`timescale 1ns / 1ps
package sbsh_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [6:0]  LEN_START   = 7'd56;

    // Byte-path operation that the front end hands to the back end.
    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_FINISH = 2'd1,
        OP_BOTH   = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- sv/sbsh_front.sv -----
// Front end: accepts input items, classifies them and queues byte commands.
`timescale 1ns / 1ps
module sbsh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_has_byte,
    input  logic           i_eom,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output sbsh_pkg::t_cmd o_cmd
);
    import sbsh_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop;
    t_cmd            cmd_in;

    // Items with neither a byte nor an end mark are dropped here.
    always_comb begin
        cmd_in.data = i_data_byte;
        if (i_has_byte && i_eom) begin
            cmd_in.op = OP_BOTH;
        end else if (i_eom) begin
            cmd_in.op = OP_FINISH;
        end else begin
            cmd_in.op = OP_DATA;
        end
    end

    assign o_ready     = (r_cnt != QUEUE_DEPTH[PW:0]);
    assign push        = i_valid && o_ready && (i_has_byte || i_eom);
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- sv/sbsh_back.sv -----
// Back end: block buffering, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module sbsh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  sbsh_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word
);
    import sbsh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_LOAD = 5'b00100,
        S_RUN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [31:0]          r_h [8];
    logic [31:0]          r_v [8];
    logic [31:0]          r_w [16];
    logic [31:0]          r_buf [BLOCK_BYTES / 4];
    logic [5:0]           r_fill;
    logic [COUNT_W-1:0]   r_count;
    logic [5:0]           r_round;
    logic [3:0]           r_load;
    logic                 r_fin;
    logic [6:0]           r_pad;
    logic [63:0]          r_bits;
    logic [2:0]           r_oidx;
    logic [7:0]           pad_byte;
    logic [31:0]          w_new, t1, t2;

    assign o_cmd_ready   = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // Padding byte sequence: 0x80, zeros, then the big-endian bit length.
    always_comb begin
        if (r_pad == 7'd0) begin
            pad_byte = PAD_BYTE;
        end else if (r_pad[6] && ({1'b0, r_fill} >= LEN_START)) begin
            pad_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign w_new   = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_round] + r_w[0];
    assign t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd_valid) begin
                if (i_cmd.op == OP_FINISH) begin
                    n_state = S_PAD;
                end else if (r_fill == 6'd63) begin
                    n_state = S_LOAD;
                end else if (i_cmd.op == OP_BOTH) begin
                    n_state = S_PAD;
                end
            end
            S_PAD:  if (r_fill == 6'd63) n_state = S_LOAD;
            S_LOAD: if (r_load == 4'd15) n_state = S_RUN;
            S_RUN:  if (r_round == 6'd63) begin
                n_state = !r_fin ? S_IDLE : ((r_pad[6] && r_fill == 6'd0) ? S_OUT : S_PAD);
            end
            S_OUT:  if (i_ready && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Block buffer memory: four bytes per word, the first byte in the high lane.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid && i_cmd.op != OP_FINISH) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_cmd.data;
        end else if (r_state == S_PAD) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= pad_byte;
        end
    end

    // Datapath and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_fin   <= 1'b0;
            r_pad   <= '0;
            r_load  <= '0;
            r_round <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_cmd_valid) begin
                    if (i_cmd.op != OP_FINISH) begin
                        r_fill <= r_fill + 1'b1;
                        if (r_count != {COUNT_W{1'b1}}) r_count <= r_count + 1'b1;
                        r_bits <= {(r_count != {COUNT_W{1'b1}}) ?
                                   r_count + 1'b1 : r_count, 3'b000};
                    end else begin
                        r_bits <= {r_count, 3'b000};
                    end
                    r_fin <= (i_cmd.op != OP_DATA);
                    r_pad <= '0;
                end
                S_PAD: begin
                    r_fill <= r_fill + 1'b1;
                    if (r_pad == 7'd0) begin
                        r_pad <= 7'd1;
                    end else if (r_fill == 6'd55 && (r_pad[6] || r_pad != 7'd0)) begin
                        r_pad <= (r_pad | 7'b1000000);
                    end
                    if (r_fill == 6'd55 && r_pad == 7'd0) r_pad <= 7'b1000001;
                end
                S_LOAD: begin
                    r_w[r_load] <= r_buf[r_load];
                    r_load <= r_load + 1'b1;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_round <= '0;
                end
                S_RUN: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_round <= r_round + 1'b1;
                    if (r_round == 6'd63) begin
                        r_h[0] <= r_h[0] + t1 + t2;
                        r_h[1] <= r_h[1] + r_v[0];
                        r_h[2] <= r_h[2] + r_v[1];
                        r_h[3] <= r_h[3] + r_v[2];
                        r_h[4] <= r_h[4] + r_v[3] + t1;
                        r_h[5] <= r_h[5] + r_v[4];
                        r_h[6] <= r_h[6] + r_v[5];
                        r_h[7] <= r_h[7] + r_v[6];
                        r_oidx <= '0;
                    end
                end
                S_OUT: if (i_ready) begin
                    r_oidx <= r_oidx + 1'b1;
                    if (r_oidx == 3'd7) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= INIT_HASH[i];
                        r_count <= '0;
                        r_fill  <= '0;
                        r_fin   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- sv/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte-stream hasher.
//
//  Channel  Dir  tdata                 tuser                 tlast
//  s_axis   in   [7:0] data_byte       [0] has_byte          end_of_message
//  m_axis   out  [31:0] digest_word    [2:0] word_index      last_word
//
// A byte is normally just stored; the byte that fills a block adds the load of
// the block and the rounds of the single shared round unit. An end mark writes
// the padding one byte per cycle up to the end of the block and compresses; if
// the length does not fit, a second padding block and compression follow. Eight
// words then leave, one per accepted cycle. A four-entry command
// queue parts input from the compression engine and stalls the input when full.
// Reset is synchronous, active low, and restores the initial hash values.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sbsh_pkg::*;

    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    sbsh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data_byte(s_axis_tdata), .i_has_byte(s_axis_tuser[0]), .i_eom(s_axis_tlast),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    sbsh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_digest_word(m_axis_tdata), .o_word_index(m_axis_tuser),
        .o_last_word(m_axis_tlast)
    );

    // The last flag rides only on word seven.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("last flag out of place");

    // Word index advances after each accepted word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("word index skipped");
endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
module tb;
    import sbsh_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_mark;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sha256_byte_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_msg_item   pending_items[$];
    t_digest_out expected_words[$];

    // Predictor state.
    logic [31:0] run_hash [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [60:0] msg_len;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          sender_pause;
    bit          recv_hold;
    int unsigned hold_count;
    int unsigned errors;
    int unsigned idle_cycles;
    int unsigned items_sent;
    int unsigned words_seen;
    int unsigned messages;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Append one item to the tail of the pending queue.
    task automatic add_pending(input t_msg_item it);
        pending_items = {pending_items, it};
    endtask

    // One SHA-256 compression of the buffered block into the running hash.
    task automatic compress_buffer();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        {a, b, c, d, e, f, g, h} = {run_hash[0], run_hash[1], run_hash[2], run_hash[3],
                                    run_hash[4], run_hash[5], run_hash[6], run_hash[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) ^ 32'h0;
            t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
        run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
    endtask

    task automatic append_byte(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 64) begin
            compress_buffer();
            blk_fill = 0;
        end
    endtask

    task automatic reset_hash();
        for (int i = 0; i < 8; i++)
            run_hash[i] = INIT_HASH[i];
        blk_fill = 0;
        msg_len  = '0;
    endtask

    // Work out the digest words that an accepted item produces.
    task automatic predict_digest(input t_msg_item it);
        logic [63:0] bit_len;
        t_digest_out o;
        if (it.has_byte) begin
            append_byte(it.data_byte);
            if (msg_len != '1)
                msg_len++;
        end
        if (it.end_mark) begin
            bit_len = {msg_len, 3'b000};
            append_byte(PAD_BYTE);
            while (blk_fill != 56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                o.digest_word = run_hash[i];
                o.word_index  = i[2:0];
                o.last_word   = (i == 7);
                expected_words = {expected_words, o};
            end
            messages++;
            reset_hash();
        end
    endtask

    function automatic t_msg_item make_item(input logic [7:0] b, input bit hb, input bit em);
        t_msg_item it;
        it.data_byte = b;
        it.has_byte  = hb;
        it.end_mark  = em;
        return it;
    endfunction

    // Queue a message of random bytes with the end mark on the last byte or alone.
    task automatic queue_message(input int unsigned len);
        bit sep;
        sep = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                add_pending(make_item(8'($urandom), 1'b0, 1'b0));
            add_pending(make_item(8'($urandom), 1'b1, !sep && (i == len - 1)));
        end
        if (sep)
            add_pending(make_item(8'($urandom), 1'b0, 1'b1));
    endtask

    task automatic drain_wait();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: offers the head of the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_digest(make_item(s_axis_tdata, s_axis_tuser[0], s_axis_tlast));
                items_sent++;
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (pending_items.size() != 0 && !sender_pause
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_msg_item nx;
                    nx = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nx.data_byte;
                    s_axis_tuser  <= nx.has_byte;
                    s_axis_tlast  <= nx.end_mark;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready, long hold-off on request, checks each word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("digest word with no expectation: %h", m_axis_tdata);
                    errors++;
                end else begin
                    t_digest_out ex;
                    ex = expected_words.pop_front();
                    if (m_axis_tdata !== ex.digest_word) begin
                        $error("digest_word expected %h got %h", ex.digest_word, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== ex.word_index) begin
                        $error("word_index expected %0d got %0d", ex.word_index, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tlast !== ex.last_word) begin
                        $error("last_word expected %0d got %0d", ex.last_word, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (recv_hold && hold_count < HOLD_CYCLES) begin
                hold_count <= hold_count + 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sender_pause  = 1'b0;
        recv_hold     = 1'b0;
        hold_count    = 0;
        errors = 0; idle_cycles = 0; items_sent = 0; words_seen = 0; messages = 0;
        reset_hash();
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, extreme bytes, ignored byte, idle item, byte with end.
        add_pending(make_item(8'hff, 1'b0, 1'b1));
        add_pending(make_item(8'hff, 1'b0, 1'b0));
        add_pending(make_item(8'h00, 1'b1, 1'b0));
        add_pending(make_item(8'hff, 1'b1, 1'b0));
        add_pending(make_item(8'h55, 1'b0, 1'b0));
        add_pending(make_item(8'haa, 1'b1, 1'b1));
        add_pending(make_item(8'h61, 1'b1, 1'b1));
        for (int i = 0; i < 15; i++)
            add_pending(make_item(8'h5a ^ i[7:0], 1'b1, 1'b0));
        add_pending(make_item(8'h00, 1'b0, 1'b1));
        drain_wait();

        // Padding boundaries: one or two compressions at 55/56, and full blocks.
        send_idle_pct = 7; recv_idle_pct = 57;
        queue_message(55); queue_message(56); queue_message(63); queue_message(64);
        drain_wait();

        // Long receiver hold-off while the sender keeps offering items.
        recv_hold = 1'b1;
        send_idle_pct = 0;
        queue_message(3); queue_message(5); queue_message(2); queue_message(10);
        wait (hold_count >= HOLD_CYCLES);
        recv_hold = 1'b0;
        drain_wait();

        send_idle_pct = 57; recv_idle_pct = 7;
        while (items_sent + pending_items.size() < 300)
            queue_message($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 70));
        drain_wait();

        // Sender pause until every expected word has come.
        sender_pause = 1'b1;
        drain_wait();
        sender_pause = 1'b0;

        send_idle_pct = 0; recv_idle_pct = 0;
        while (items_sent + pending_items.size() < 430)
            queue_message($urandom_range(0, 20));
        drain_wait();

        $display("Covered %0d items, %0d messages, %0d digest words checked.",
                 items_sent, messages, words_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sha256_byte_stream_hasher.f -----
sv/sbsh_pkg.sv
sv/sbsh_front.sv
sv/sbsh_back.sv
sv/sha256_byte_stream_hasher.sv
sim/tb.sv
